>>> rtl/hrm_pkg.sv
// shared constants and codes for the hdr radiance merge block
`timescale 1ns / 1ps

package hrm_pkg;

  // exposure lanes built into the datapath
  localparam int EXPOSURES = 4;

  localparam int CURVE_W = 24;
  localparam int CURVE_DEPTH = 256;
  localparam int SAMPLE_W = 8;

  // configuration register indexes
  localparam logic [2:0] REG_EXPOSURE_COUNT = 3'd0;
  localparam logic [2:0] REG_LOG_TIME_0 = 3'd1;
  localparam logic [2:0] REG_LOG_TIME_3 = 3'd4;

  // input operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_MERGE = 1'b1;

  // divider layout: quotient bits retired per stage and stage count
  localparam int DIV_STAGES = 5;
  localparam int DIV_STEPS = 5;
  localparam int Q_W = DIV_STAGES * DIV_STEPS;

  // exp constants
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam logic [30:0] ONE_Q30 = 31'd1073741824;
  localparam int TAYLOR_TERMS = 13;

  // floor((2^32 - 1) / n) for n = 1 .. 13, used to divide taylor terms
  localparam logic [31:0] RECIP [TAYLOR_TERMS] = '{
    32'hFFFFFFFF / 1, 32'hFFFFFFFF / 2, 32'hFFFFFFFF / 3, 32'hFFFFFFFF / 4,
    32'hFFFFFFFF / 5, 32'hFFFFFFFF / 6, 32'hFFFFFFFF / 7, 32'hFFFFFFFF / 8,
    32'hFFFFFFFF / 9, 32'hFFFFFFFF / 10, 32'hFFFFFFFF / 11, 32'hFFFFFFFF / 12,
    32'hFFFFFFFF / 13
  };

endpackage

>>> rtl/hrm_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module hrm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/hdr_radiance_merge_top.sv
// hdr radiance merge: curve store, weighted mean, pipelined divide and exp
`timescale 1ns / 1ps
// throughput: one transfer per cycle while the skid register is empty, set by the
// fully pipelined divider and taylor chain
// curve writes produce no result
// rst (synchronous) clears the valid bits, the output valid and skid flags and the
// configuration (exposure_count = 4, log times = 0); the curve store is not cleared

module hdr_radiance_merge_top (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [7:0]  curve_index,
  input  logic signed [23:0] curve_value,
  input  logic [7:0]  sample_0,
  input  logic [7:0]  sample_1,
  input  logic [7:0]  sample_2,
  input  logic [7:0]  sample_3,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] radiance,
  output logic        saturated
);

  // stage numbering along the valid shift line
  localparam int ST_DIV0 = 3;
  localparam int ST_MEAN = ST_DIV0 + hrm_pkg::DIV_STAGES + 1;
  localparam int ST_Y = ST_MEAN + 1;
  localparam int ST_R = ST_Y + 1;
  localparam int ST_T0 = ST_R + 1;
  localparam int ST_F = ST_T0 + 3 * hrm_pkg::TAYLOR_TERMS;
  localparam int NST = ST_F + 1;

  typedef struct packed {
    logic [9:0]            rem;
    logic [hrm_pkg::Q_W-1:0] low;
    logic [hrm_pkg::Q_W-1:0] q;
    logic [9:0]            w;
    logic                  neg;
    logic                  zero;
  } div_t;

  typedef struct packed {
    logic [29:0]        r;
    logic signed [10:0] k;
    logic               zero;
    logic [30:0]        term;
    logic [31:0]        sum;
    logic [29:0]        p;
    logic [29:0]        q0;
  } tay_t;

  typedef struct packed {
    logic [31:0] radiance;
    logic        saturated;
  } res_t;

  // ---------------------------------------------------------------- config
  logic [2:0]         exposure_count;
  logic signed [23:0] log_time [hrm_pkg::EXPOSURES];

  always_ff @(posedge clk) begin
    if (rst) begin
      exposure_count <= 3'd4;
      for (int i = 0; i < hrm_pkg::EXPOSURES; i++) begin
        log_time[i] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == hrm_pkg::REG_EXPOSURE_COUNT) begin
        exposure_count <= cfg_data[2:0];
      end
      for (int i = 0; i < hrm_pkg::EXPOSURES; i++) begin
        if (cfg_index == 3'(hrm_pkg::REG_LOG_TIME_0 + 3'(i)) &&
            cfg_index <= hrm_pkg::REG_LOG_TIME_3) begin
          log_time[i] <= cfg_data;
        end
      end
    end
  end

  // ---------------------------------------------------------------- flow control
  // the whole pipeline moves together; a skid register behind the output
  // register catches the one result that arrives while the output is stalled
  logic           skid_full;
  logic           en;
  logic           in_xfer;
  logic [NST-1:0] vld;

  assign en = !skid_full;
  assign in_stall = skid_full;
  assign in_xfer = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], in_xfer && (operation == hrm_pkg::OP_MERGE)};
    end
  end

  // ---------------------------------------------------------------- curve store
  // one copy per lane so every lane reads in the same cycle
  logic [7:0]  samples [4];
  logic [23:0] curve_rd [hrm_pkg::EXPOSURES];

  assign samples[0] = sample_0;
  assign samples[1] = sample_1;
  assign samples[2] = sample_2;
  assign samples[3] = sample_3;

  for (genvar i = 0; i < hrm_pkg::EXPOSURES; i++) begin : g_curve
    hrm_ram #(
      .WIDTH(hrm_pkg::CURVE_W),
      .DEPTH(hrm_pkg::CURVE_DEPTH)
    ) u_curve (
      .clk  (clk),
      .we   (in_xfer && (operation == hrm_pkg::OP_WRITE)),
      .waddr(curve_index),
      .wdata(curve_value),
      .re   (en),
      .raddr(samples[i]),
      .rdata(curve_rd[i])
    );
  end

  // ---------------------------------------------------------------- stage 0: weights
  // triangular weight times 128, zero for lanes not in use
  logic [7:0] s0_w [hrm_pkg::EXPOSURES];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < hrm_pkg::EXPOSURES; i++) begin
        if (exposure_count > 3'(i)) begin
          s0_w[i] <= (samples[i] > 8'd128) ? 8'(9'd256 - {1'b0, samples[i]}) : samples[i];
        end else begin
          s0_w[i] <= '0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- stage 1: lane products
  logic signed [33:0] s1_prod [hrm_pkg::EXPOSURES];
  logic [9:0]         s1_wsum;
  logic [9:0]         s1_wsum_next;

  always_comb begin
    s1_wsum_next = '0;
    for (int i = 0; i < hrm_pkg::EXPOSURES; i++) begin
      s1_wsum_next = s1_wsum_next + 10'(s0_w[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < hrm_pkg::EXPOSURES; i++) begin
        s1_prod[i] <= $signed({1'b0, s0_w[i]}) *
                      (25'($signed(curve_rd[i])) - 25'(log_time[i]));
      end
      s1_wsum <= s1_wsum_next;
    end
  end

  // ---------------------------------------------------------------- stage 2: sums
  logic signed [35:0] s2_ssum_next;
  logic [33:0]        s2_mag;
  logic               s2_neg;
  logic [9:0]         s2_w;

  always_comb begin
    s2_ssum_next = '0;
    for (int i = 0; i < hrm_pkg::EXPOSURES; i++) begin
      s2_ssum_next = s2_ssum_next + 36'(s1_prod[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_neg <= s2_ssum_next[35];
      s2_mag <= s2_ssum_next[35] ? 34'(-s2_ssum_next) : s2_ssum_next[33:0];
      s2_w <= s1_wsum;
    end
  end

  // ---------------------------------------------------------------- divider
  // round to nearest by adding half the divisor, then restoring division;
  // the top numerator bits are known to stay below the divisor
  logic [33:0] num;
  div_t        div_s [hrm_pkg::DIV_STAGES + 1];

  assign num = s2_mag + 34'(s2_w >> 1);

  always_ff @(posedge clk) begin
    if (en) begin
      div_s[0].rem <= {1'b0, num[33:hrm_pkg::Q_W]};
      div_s[0].low <= num[hrm_pkg::Q_W-1:0];
      div_s[0].q <= '0;
      div_s[0].w <= s2_w;
      div_s[0].neg <= s2_neg;
      div_s[0].zero <= (s2_w == '0);
    end
  end

  for (genvar d = 0; d < hrm_pkg::DIV_STAGES; d++) begin : g_div
    div_t       div_next;
    logic [10:0] trial;

    always_comb begin
      div_next = div_s[d];
      trial = '0;
      for (int s = 0; s < hrm_pkg::DIV_STEPS; s++) begin
        trial = {div_next.rem, div_next.low[hrm_pkg::Q_W-1]};
        div_next.low = div_next.low << 1;
        if (trial >= {1'b0, div_next.w}) begin
          div_next.rem = 10'(trial - {1'b0, div_next.w});
          div_next.q = {div_next.q[hrm_pkg::Q_W-2:0], 1'b1};
        end else begin
          div_next.rem = trial[9:0];
          div_next.q = {div_next.q[hrm_pkg::Q_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        div_s[d+1] <= div_next;
      end
    end
  end

  // ---------------------------------------------------------------- mean and exp argument
  localparam int DL = hrm_pkg::DIV_STAGES;

  logic signed [25:0] mean;
  logic               mean_zero;
  logic signed [56:0] y;
  logic               y_zero;

  always_ff @(posedge clk) begin
    if (en) begin
      mean <= div_s[DL].neg ? -$signed({1'b0, div_s[DL].q}) : $signed({1'b0, div_s[DL].q});
      mean_zero <= div_s[DL].zero;
      y <= mean * $signed({1'b0, hrm_pkg::LOG2E_Q30});
      y_zero <= mean_zero;
    end
  end

  // y in q.46: integer part k, fraction scaled back to natural log in q.30
  tay_t        tc [hrm_pkg::TAYLOR_TERMS + 1];
  logic [59:0] r_full;

  assign r_full = y[45:16] * hrm_pkg::LN2_Q30;

  always_ff @(posedge clk) begin
    if (en) begin
      tc[0].r <= r_full[59:30];
      tc[0].k <= y[56:46];
      tc[0].zero <= y_zero;
      tc[0].term <= hrm_pkg::ONE_Q30;
      tc[0].sum <= 32'(hrm_pkg::ONE_Q30);
      tc[0].p <= '0;
      tc[0].q0 <= '0;
    end
  end

  // ---------------------------------------------------------------- taylor chain
  // each term: multiply by r, divide by n through a reciprocal, correct by one
  for (genvar j = 0; j < hrm_pkg::TAYLOR_TERMS; j++) begin : g_tay
    localparam logic [3:0] N = 4'(j + 1);

    tay_t        ta;
    tay_t        tb;
    tay_t        ta_next;
    tay_t        tb_next;
    tay_t        tc_next;
    logic [60:0] mul_tr;
    logic [61:0] mul_rc;
    logic [33:0] rem;

    assign mul_tr = tc[j].term * tc[j].r;
    assign mul_rc = ta.p * hrm_pkg::RECIP[j];
    assign rem = 34'(tb.p) - 34'(tb.q0) * 34'(N);

    always_comb begin
      ta_next = tc[j];
      ta_next.p = mul_tr[59:30];
      tb_next = ta;
      tb_next.q0 = mul_rc[61:32];
      tc_next = tb;
      if (rem >= 34'(N)) begin
        tc_next.term = 31'(tb.q0) + 31'd1;
        tc_next.sum = tb.sum + 32'(tb.q0) + 32'd1;
      end else begin
        tc_next.term = 31'(tb.q0);
        tc_next.sum = tb.sum + 32'(tb.q0);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ta <= ta_next;
        tb <= tb_next;
        tc[j+1] <= tc_next;
      end
    end
  end

  // ---------------------------------------------------------------- final scale to q16.16
  localparam int TL = hrm_pkg::TAYLOR_TERMS;

  tay_t               tf;
  res_t               f_res;
  res_t               f_next;
  logic signed [11:0] shv;
  logic [5:0]         sh;
  logic [40:0]        rnd;
  logic [32:0]        up;

  assign tf = tc[TL];

  always_comb begin
    shv = 12'sd14 - 12'(tf.k);
    sh = shv[5:0];
    rnd = 41'(tf.sum) + (41'd1 << (sh - 6'd1));
    up = 33'(tf.sum) << tf.k[0];
    f_next.radiance = '0;
    f_next.saturated = 1'b0;
    if (tf.zero) begin
      // no usable sample: radiance of one
      f_next.radiance = 32'h0001_0000;
    end else if (tf.k >= 11'sd16) begin
      f_next.radiance = '1;
      f_next.saturated = 1'b1;
    end else if (tf.k >= 11'sd14) begin
      // k of 14 or 15: shift left by k - 14, which is the low bit of k
      if (up[32]) begin
        f_next.radiance = '1;
        f_next.saturated = 1'b1;
      end else begin
        f_next.radiance = up[31:0];
      end
    end else if (shv < 12'sd40) begin
      f_next.radiance = 32'(rnd >> sh);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_res <= f_next;
    end
  end

  // ---------------------------------------------------------------- output and skid
  res_t out_res;
  res_t skid_res;
  logic out_take;

  assign out_take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (out_take) begin
        out_res <= skid_res;
        skid_full <= 1'b0;
      end
    end else if (!out_valid || out_take) begin
      out_valid <= vld[NST-1];
      out_res <= f_res;
    end else if (vld[NST-1]) begin
      skid_res <= f_res;
      skid_full <= 1'b1;
    end
  end

  assign radiance = out_res.radiance;
  assign saturated = out_res.saturated;

endmodule

>>> rtl/hrm_checker.sv
// port-level checks for the hdr radiance merge top level
`timescale 1ns / 1ps

module hrm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] radiance,
  input logic        saturated
);

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(radiance) && $stable(saturated))
    else $error("stalled result changed");

  // the saturation flag only comes with the clipped maximum
  a_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> radiance == 32'hFFFF_FFFF)
    else $error("saturated without maximum radiance");

  // input stalls only while a result is waiting at the output
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  // reset empties the output and releases the input
  a_rst: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("reset did not clear the output");

endmodule

bind hdr_radiance_merge_top hrm_checker u_hrm_checker (
  .clk      (clk),
  .rst      (rst),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .radiance (radiance),
  .saturated(saturated)
);
